[design/lir_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Sample and position widths, register indexes, and the items that pass
// between the front, the queue, the walk sequencer and the output stage.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRAC_BITS     = 16;
    // Step covers 1/32 .. 16 in Q.FRAC_BITS, with five integer bits to hold 16.
    localparam int STEP_BITS     = FRAC_BITS + 5;
    localparam int COUNT_BITS    = 24;
    // Position while walking is below one plus a step.
    localparam int POS_BITS      = STEP_BITS + 1;
    localparam int RUN_CAP       = 32;
    localparam int ITER_BITS     = $clog2(RUN_CAP + 1);
    localparam int PROD_BITS     = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = (STEP_BITS > COUNT_BITS) ? STEP_BITS : COUNT_BITS;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] REG_STEP         = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_COUNT = CFG_IDX_BITS'(1);

    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1) << FRAC_BITS;
    localparam logic [POS_BITS-1:0]  ONE_POS    = POS_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic                          last_of_run;
        logic                          end_of_stream;
    } t_out_item;

    // One classified input: the interval it closes and how to walk it.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] prev;
        logic signed [SAMPLE_BITS-1:0] cur;
        logic                          interp;
        logic                          last;
    } t_job;

    // Registered product or end-of-item token toward the output stage.
    typedef struct packed {
        logic                          is_token;
        logic                          last;
        logic                          eos;
        logic signed [PROD_BITS-1:0]   prod;
        logic signed [SAMPLE_BITS-1:0] base;
    } t_mul;

endpackage
`default_nettype wire

[design/lir_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lir_front: request intake
// Accepts input requests, pairs each with the previous sample of its stream
// and tags whether it closes an interpolation interval.
// ----------------------------------------------------------------------------
module lir_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  lir_pkg::t_in_item   i_data,
    output logic                o_stall,
    input  wire                 i_full,
    output logic                o_push,
    output lir_pkg::t_job       o_job
);
    import lir_pkg::*;

    logic                          r_have_prev;
    logic signed [SAMPLE_BITS-1:0] r_prev;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_job.prev   = r_prev;
        o_job.cur    = i_data.sample;
        o_job.interp = r_have_prev;
        o_job.last   = i_data.last;
    end

    // Drop stream history after the last sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev      <= '0;
        end else if (o_push) begin
            r_have_prev <= !i_data.last;
            r_prev      <= i_data.last ? '0 : i_data.sample;
        end
    end

endmodule
`default_nettype wire

[design/lir_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lir_queue: job queue
// Short FIFO of classified jobs between the intake and the walk sequencer.
// ----------------------------------------------------------------------------
module lir_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  lir_pkg::t_job       i_job,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output lir_pkg::t_job       o_job
);
    import lir_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_cnt;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        ptr_inc = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
    endfunction

    assign o_full  = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

[design/lir_walk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lir_walk: position walk sequencer
// Steps output positions over each job's interval (last job: and its hold
// interval), one a cycle unless stalled; counts outputs, registers products.
// ----------------------------------------------------------------------------
module lir_walk (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_job_valid,
    input  lir_pkg::t_job                     i_job,
    output logic                              o_pop,
    input  wire [lir_pkg::STEP_BITS-1:0]      i_step,
    input  wire [lir_pkg::COUNT_BITS-1:0]     i_out_count,
    output logic                              o_mul_valid,
    output lir_pkg::t_mul                     o_mul,
    input  wire                               i_mul_take
);
    import lir_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic                  r_phase, n_phase;
    logic [ITER_BITS-1:0]  r_iter,  n_iter;
    logic [POS_BITS-1:0]   r_pos,   n_pos;
    logic [COUNT_BITS-1:0] r_cnt,   n_cnt;
    t_job                  r_job,   n_job;
    logic                  r_mv,    n_mv;
    t_mul                  r_m,     n_m;

    logic                          m_ready;
    logic                          in_range;
    logic                          can_step;
    logic                          do_emit;
    logic signed [SAMPLE_BITS-1:0] base;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac;
    logic signed [PROD_BITS-1:0]   prod;

    assign m_ready  = !r_mv || i_mul_take;
    assign in_range = (r_pos < ONE_POS);
    assign can_step = in_range && (r_iter != ITER_BITS'(RUN_CAP));
    assign do_emit  = (r_cnt < i_out_count);
    // Hold phase walks cur against itself, so the product is zero.
    assign base     = r_phase ? r_job.cur : r_job.prev;
    assign diff     = {r_job.cur[SAMPLE_BITS-1], r_job.cur} - {base[SAMPLE_BITS-1], base};
    assign frac     = {1'b0, r_pos[FRAC_BITS-1:0]};
    assign prod     = diff * frac;

    assign o_pop       = (r_state == ST_IDLE) && i_job_valid;
    assign o_mul_valid = r_mv;
    assign o_mul       = r_m;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_iter  = r_iter;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_job   = r_job;
        n_mv    = r_mv && !i_mul_take;
        n_m     = r_m;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_job  = i_job;
                    n_iter = '0;
                    if (i_job.interp) begin
                        n_state = ST_WALK;
                        n_phase = 1'b0;
                    end else if (i_job.last) begin
                        n_state = ST_WALK;
                        n_phase = 1'b1;
                    end else begin
                        n_state = ST_END;
                    end
                end
            end
            ST_WALK: begin
                if (m_ready) begin
                    if (can_step) begin
                        if (do_emit) begin
                            n_mv         = 1'b1;
                            n_m.is_token = 1'b0;
                            n_m.last     = 1'b0;
                            n_m.eos      = ((r_cnt + COUNT_BITS'(1)) == i_out_count);
                            n_m.prod     = prod;
                            n_m.base     = base;
                            n_cnt        = r_cnt + COUNT_BITS'(1);
                        end
                        n_pos  = r_pos + POS_BITS'(i_step);
                        n_iter = r_iter + ITER_BITS'(1);
                    end else begin
                        // Skip what the run cap left of the interval.
                        n_pos  = in_range ? '0 : (r_pos - ONE_POS);
                        n_iter = '0;
                        if (!r_phase && r_job.last) begin
                            n_phase = 1'b1;
                        end else begin
                            n_state = ST_END;
                        end
                    end
                end
            end
            ST_END: begin
                if (m_ready) begin
                    n_mv         = 1'b1;
                    n_m.is_token = 1'b1;
                    n_m.last     = r_job.last;
                    n_m.eos      = 1'b0;
                    n_m.prod     = '0;
                    n_m.base     = '0;
                    if (r_job.last) begin
                        n_pos = '0;
                        n_cnt = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 1'b0;
            r_iter  <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_iter  <= n_iter;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_mv    <= n_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_m   <= n_m;
    end

    a_iter_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= ITER_BITS'(RUN_CAP))
        else $error("walk ran past the run cap");

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pos < (POS_BITS'(1) << STEP_BITS)))
        else $error("position out of range between jobs");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_phase) |-> r_job.last)
        else $error("hold walk on a job that is not last");

    a_stream_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && m_ready && r_job.last) |=> (r_pos == '0 && r_cnt == '0))
        else $error("stream state not cleared after last job");

endmodule
`default_nettype wire

[design/lir_emit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lir_emit: result stage
// Finishes the interpolation sum, holds one result back so the final one of
// each request can be flagged, and drives the output register.
// ----------------------------------------------------------------------------
module lir_emit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_mul_valid,
    input  lir_pkg::t_mul       i_mul,
    output logic                o_mul_take,
    output logic                o_valid,
    output lir_pkg::t_out_item  o_data,
    input  wire                 i_stall
);
    import lir_pkg::*;

    logic                          r_pv;
    logic signed [SAMPLE_BITS-1:0] r_pval;
    logic                          r_peos;
    logic                          r_ov;
    t_out_item                     r_out;

    logic                          out_free;
    logic                          push;
    logic signed [SAMPLE_BITS:0]   q;
    logic signed [SAMPLE_BITS:0]   sum;
    t_out_item                     push_item;

    assign out_free   = !r_ov || !i_stall;
    assign o_mul_take = i_mul_valid && (!r_pv || out_free);
    assign push       = o_mul_take && r_pv;

    // Arithmetic shift floors the product.
    assign q   = i_mul.prod[FRAC_BITS+SAMPLE_BITS:FRAC_BITS];
    assign sum = {i_mul.base[SAMPLE_BITS-1], i_mul.base} + q;

    always_comb begin
        push_item.out_sample    = r_pval;
        push_item.last_of_run   = i_mul.is_token;
        push_item.end_of_stream = r_peos || (i_mul.is_token && i_mul.last);
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_mul_take) begin
                r_pv <= !i_mul.is_token;
            end
            if (out_free) begin
                r_ov <= push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mul_take && !i_mul.is_token) begin
            r_pval <= sum[SAMPLE_BITS-1:0];
            r_peos <= i_mul.eos;
        end
        if (out_free && push) begin
            r_out <= push_item;
        end
    end

    a_token_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mul_take && i_mul.is_token) |=> !r_pv)
        else $error("held result survived the end of its request");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed into a stalled output register");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_free && push && i_mul.is_token) |=> (r_ov && r_out.last_of_run))
        else $error("final result of a request not flagged");

endmodule
`default_nettype wire

[design/linear_interp_resampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample-rate converter
// Mono Q1.15 stream in, resampled Q1.15 stream out, Q5.16 position step.
// ----------------------------------------------------------------------------
// Each input request closes the interval between the previous sample and the
// current one; every output position that falls inside it yields
// prev + (cur - prev) * frac, floored. The walk sequencer steps one output
// position a cycle while the output side keeps up. For each item it pops the
// job, walks every output position in the interval the item closes (at most
// 32), leaves the interval and closes the request. A last item also walks the
// final hold interval (at most 32 more positions) and leaves it before the
// request closes. The first sample of a stream only loads history: its job is
// popped and closed. A two-entry job queue keeps taking requests while the
// sequencer walks, and a held-back result plus an output register absorb
// results while the output side stalls. Production stops when output_count
// results of the stream are out; the last sample of a stream clears all
// stream state. Write step and output_count only while the block is idle.
// ----------------------------------------------------------------------------
module linear_interp_resampler (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    input  lir_pkg::t_in_item                  i_data,
    output logic                               o_stall,
    output logic                               o_valid,
    output lir_pkg::t_out_item                 o_data,
    input  wire                                i_stall,
    input  wire                                i_cfg_we,
    input  wire [lir_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire [lir_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import lir_pkg::*;

    logic [STEP_BITS-1:0]  r_step;
    logic [COUNT_BITS-1:0] r_out_count;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_job front_job;
    t_job head_job;
    logic mul_valid;
    logic mul_take;
    t_mul mul;

    // Register writes take effect at once; drop bits above each width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_out_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP: begin
                    r_step <= i_cfg_data[STEP_BITS-1:0];
                end
                REG_OUTPUT_COUNT: begin
                    r_out_count <= i_cfg_data[COUNT_BITS-1:0];
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    // Intake: pair each sample with its predecessor.
    lir_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    // Decouple intake from the walk.
    lir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Walk output positions and form products.
    lir_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .i_step      (r_step),
        .i_out_count (r_out_count),
        .o_mul_valid (mul_valid),
        .o_mul       (mul),
        .i_mul_take  (mul_take)
    );

    // Finish sums, flag run ends, drive the output.
    lir_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mul_valid (mul_valid),
        .i_mul       (mul),
        .o_mul_take  (mul_take),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule
`default_nettype wire

[verif/linear_interp_resampler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_tb: self-checking bench of the linear interpolation
// resampler
// Drives sample requests through the valid/stall input channel, predicts every
// resampled output with a cycle-free model of the position walk, and checks
// each accepted result against the oldest prediction. Covers field extremes,
// steps below and above the nominal range, output count limits, single-sample
// streams, broken streams, receiver back-pressure and sender pauses.
// ----------------------------------------------------------------------------
module linear_interp_resampler_tb;
    import lir_pkg::*;

    // Let the block finish its queued jobs after the last expected result;
    // up to three jobs, two queued and one walking, with margin.
    localparam int DRAIN_CYCLES = 300;
    localparam int PRINT_CAP    = 40;
    localparam longint unsigned UNIT_POS = 64'd1 << FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [STEP_BITS-1:0]  STEP_MAX  = {STEP_BITS{1'b1}};

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     req_valid = 1'b0;
    t_in_item                 req_data  = '0;
    logic                     req_stall;
    logic                     res_valid;
    t_out_item                res_data;
    logic                     res_stall = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx   = REG_STEP;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // Shadow configuration and stream state of the resampler
    logic [STEP_BITS-1:0]     cfg_step;
    logic [COUNT_BITS-1:0]    cfg_count;
    longint unsigned          model_pos;
    logic signed [SAMPLE_BITS-1:0] model_prev;
    bit                       model_have_prev;
    logic [COUNT_BITS-1:0]    model_emitted;

    t_out_item expected_outputs[$];   // predicted results, oldest first
    t_out_item run_results[$];        // results of the request being predicted
    t_out_item oldest_expected;

    int  error_count     = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    int  hold_off_cycles = 0;
    bit  idling_on       = 1'b1;

    linear_interp_resampler i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (req_valid),
        .i_data     (req_data),
        .o_stall    (req_stall),
        .o_valid    (res_valid),
        .o_data     (res_data),
        .i_stall    (res_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // prev + (cur - prev) * frac, shifted down: the arithmetic shift floors.
    function automatic logic signed [SAMPLE_BITS-1:0] interp_sample(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input longint unsigned               frac
    );
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(frac);
        return SAMPLE_BITS'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    // Drop the result once the stream has its full count.
    task automatic emit_result(input logic signed [SAMPLE_BITS-1:0] value);
        t_out_item r;
        if (model_emitted >= cfg_count)
            return;
        model_emitted++;
        r.out_sample    = value;
        r.last_of_run   = 1'b0;
        r.end_of_stream = (model_emitted == cfg_count);
        run_results.push_back(r);
    endtask

    // Walk one input interval; a tiny step gives up after RUN_CAP positions
    // and the next interval starts again at its position zero.
    task automatic walk_interval(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input bit                            interp
    );
        int iter;
        logic signed [SAMPLE_BITS-1:0] value;
        iter = 0;
        while (model_pos < UNIT_POS && iter < RUN_CAP) begin
            value = interp ? interp_sample(a, b, model_pos) : b;
            emit_result(value);
            model_pos += cfg_step;
            iter++;
        end
        if (model_pos < UNIT_POS)
            model_pos = UNIT_POS;
        model_pos -= UNIT_POS;
    endtask

    task automatic clear_stream_model();
        model_pos       = 0;
        model_prev      = '0;
        model_have_prev = 1'b0;
        model_emitted   = '0;
    endtask

    task automatic predict_request(input t_in_item item);
        t_out_item tail;
        run_results.delete();
        if (model_have_prev)
            walk_interval(model_prev, item.sample, 1'b1);
        if (item.last) begin
            // Hold the last sample over [N-1, N), then clear the stream.
            walk_interval(item.sample, item.sample, 1'b0);
            clear_stream_model();
            if (run_results.size() > 0) begin
                tail = run_results.pop_back();
                tail.end_of_stream = 1'b1;
                run_results.push_back(tail);
            end
        end else begin
            model_prev      = item.sample;
            model_have_prev = 1'b1;
        end
        if (run_results.size() > 0) begin
            tail = run_results.pop_back();
            tail.last_of_run = 1'b1;
            run_results.push_back(tail);
        end
        foreach (run_results[k])
            expected_outputs.push_back(run_results[k]);
    endtask

    // ------------------------------------------------------------------
    // Channel processes
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Receiver: a requested hold-off wins, otherwise stall at random.
    always @(posedge clk) begin
        if (hold_off_cycles > 0) begin
            res_stall <= 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            res_stall <= idling_on && ($urandom_range(99) < 12);
        end
    end

    // Result checker: every accepted result retires the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result, sample %0d last %0b eos %0b",
                                          res_data.out_sample, res_data.last_of_run,
                                          res_data.end_of_stream));
            end else begin
                oldest_expected = expected_outputs.pop_front();
                results_checked++;
                if (res_data.out_sample !== oldest_expected.out_sample)
                    report_mismatch($sformatf("result %0d out_sample %0d, want %0d",
                                              results_checked, res_data.out_sample,
                                              oldest_expected.out_sample));
                if (res_data.last_of_run !== oldest_expected.last_of_run)
                    report_mismatch($sformatf("result %0d last_of_run %0b, want %0b",
                                              results_checked, res_data.last_of_run,
                                              oldest_expected.last_of_run));
                if (res_data.end_of_stream !== oldest_expected.end_of_stream)
                    report_mismatch($sformatf("result %0d end_of_stream %0b, want %0b",
                                              results_checked, res_data.end_of_stream,
                                              oldest_expected.end_of_stream));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one request after a random gap; hold it until accepted, then
    // predict its results. Valid stays high so back-to-back requests never
    // see valid lowered and raised in one step.
    task automatic send_request(input t_in_item item);
        int gap;
        gap = 0;
        while (idling_on && $urandom_range(99) < 12)
            gap++;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do @(posedge clk); while (req_stall);
        requests_sent++;
        predict_request(item);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit last);
        t_in_item item;
        item.sample = s;
        item.last   = last;
        send_request(item);
    endtask

    // Idle the sender and wait until every predicted result is in and the
    // block has had time to finish any request that yields nothing.
    task automatic settle();
        req_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers; junk above the step width must be ignored.
    task automatic program_resampler(input logic [STEP_BITS-1:0] step,
                                     input logic [COUNT_BITS-1:0] count);
        logic [CFG_DATA_BITS-1:0] step_word;
        step_word = CFG_DATA_BITS'($urandom);
        step_word[STEP_BITS-1:0] = step;
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_STEP;
        cfg_data <= step_word;
        @(posedge clk);
        cfg_idx  <= REG_OUTPUT_COUNT;
        cfg_data <= CFG_DATA_BITS'(count);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_step  = step;
        cfg_count = count;
        settings_used++;
    endtask

    function automatic logic [STEP_BITS-1:0] pick_step();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return STEP_BITS'($urandom_range(2047, 0));            // below range
        else if (r < 14)
            return STEP_BITS'($urandom_range(STEP_MAX, 1048577));  // above range
        else if (r < 50)
            return STEP_BITS'($urandom_range(32768, 2048));        // upsampling
        else if (r < 85)
            return STEP_BITS'($urandom_range(131072, 32768));
        else
            return STEP_BITS'($urandom_range(1048576, 131072));
    endfunction

    function automatic logic [COUNT_BITS-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return COUNT_BITS'($urandom_range(3, 0));
        else if (r < 30)
            return COUNT_BITS'($urandom_range(40, 1));
        else if (r < 45)
            return COUNT_MAX;
        else
            return COUNT_BITS'($urandom_range(1000, 100));
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else if (r < 10)
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            return SAMPLE_BITS'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic apply_reset();
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_step  = STEP_RESET;
        cfg_count = '0;
        clear_stream_model();
    endtask

    // Reset leaves output_count at zero: nothing may come out.
    task automatic test_reset_defaults();
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd9, 1'b1);
        settle();
    endtask

    task automatic test_directed_cases();
        // Unity step over the sample extremes
        program_resampler(STEP_BITS'(65536), COUNT_MAX);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b1);
        settle();
        // Half step across the widest negative swing
        program_resampler(STEP_BITS'(32768), COUNT_MAX);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        settle();
        // Lowest nominal step: full runs of 32 per interval
        program_resampler(STEP_BITS'(2048), COUNT_MAX);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
        settle();
        // Widest step the register holds
        program_resampler(STEP_MAX, COUNT_MAX);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd7, 1'b1);
        settle();
        // Zero step: each interval is cut off at the run cap
        program_resampler('0, COUNT_MAX);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b1);
        settle();
        // A stream of one sample that is also the last
        program_resampler(STEP_BITS'(40000), COUNT_MAX);
        send_sample(16'sd12345, 1'b1);
        settle();
        // Count reached mid-stream: positions advance silently
        program_resampler(STEP_BITS'(16384), COUNT_BITS'(5));
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd4, 1'b1);
        settle();
    endtask

    // Mostly well-formed streams with random content; some streams carry
    // random last flags so they break off or run on into the next.
    task automatic test_random_streams(input int target, input bit with_idling);
        int  sent;
        int  len;
        bit  broken;
        idling_on = with_idling;
        sent = 0;
        settle();
        program_resampler(pick_step(), pick_count());
        while (sent < target) begin
            if ($urandom_range(99) < 25) begin
                settle();
                program_resampler(pick_step(), pick_count());
            end
            broken = ($urandom_range(99) < 15);
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            for (int k = 0; k < len; k++)
                send_sample(pick_sample(), broken ? bit'($urandom_range(1)) : (k == len - 1));
            sent += len;
        end
        settle();
        idling_on = 1'b1;
    endtask

    // Hold the receiver off while requests keep coming: the job queue fills
    // and the input side must stall.
    task automatic test_receiver_hold();
        settle();
        program_resampler(STEP_BITS'(2048), COUNT_MAX);
        hold_off_cycles = 400;
        for (int k = 0; k < 24; k++)
            send_sample(pick_sample(), k == 23);
        settle();
    endtask

    // Pause the sender mid-stream until everything is out, rewrite the
    // registers, then finish the stream with the new settings.
    task automatic test_sender_pause();
        repeat (4) begin
            settle();
            program_resampler(pick_step(), COUNT_MAX);
            for (int k = 0; k < 5; k++)
                send_sample(pick_sample(), 1'b0);
            settle();
            program_resampler(pick_step(), pick_count());
            for (int k = 0; k < 5; k++)
                send_sample(pick_sample(), k == 4);
        end
        settle();
    endtask

    initial begin
        apply_reset();
        test_reset_defaults();
        test_directed_cases();
        test_random_streams(130, 1'b1);
        test_random_streams(60, 1'b0);
        test_receiver_hold();
        test_sender_pause();
        test_random_streams(170, 1'b1);
        settle();
        $display("linear_interp_resampler_tb: %0d requests sent, %0d results checked, %0d settings",
                 requests_sent, results_checked, settings_used);
        $display("linear_interp_resampler_tb: extremes, odd steps, count limits, hold-off, pauses");
        if (error_count == 0)
            $display("linear_interp_resampler_tb: done, clean");
        else
            $display("linear_interp_resampler_tb: done, errors");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("linear_interp_resampler_tb: done, errors");
        $finish;
    end

endmodule
